// ----- hw/rtl/kdq_pkg.sv -----
// Shared types, codes and helpers of the key debounce and event queue block.
package kdq_pkg;

	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_KEY_EDGE   = 3'd1,
		CMD_TAKE_SHORT = 3'd2,
		CMD_TAKE_LONG  = 3'd3,
		CMD_CLEAR      = 3'd4,
		CMD_ARM_GUARD  = 3'd5,
		CMD_UPD_GUARD  = 3'd6,
		CMD_LONG_REACH = 3'd7
	} cmd_t;

	localparam logic [1:0] LK_NONE    = 2'd0;
	localparam logic [1:0] LK_BACK    = 2'd1;
	localparam logic [1:0] LK_CONFIRM = 2'd2;
	localparam logic [1:0] LK_INVALID = 2'd3;

	localparam logic [1:0] KEY_IDX_BACK    = 2'd0;
	localparam logic [1:0] KEY_IDX_CONFIRM = 2'd3;

	localparam logic CFG_DEBOUNCE = 1'b0;
	localparam logic CFG_GUARD    = 1'b1;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [15:0] GUARD_RESET    = 16'd200;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       flush;
		logic [1:0] push_key;
	} ring_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} ring_stat_t;

	typedef struct packed {
		logic       short_valid;
		logic [1:0] short_key;
		logic [1:0] long_action;
		logic       edge_accepted;
		logic       timer_start;
		logic       timer_stop;
		logic [1:0] tracked_key;
		logic       guard_active;
		logic [7:0] overflow_count;
		logic [2:0] queue_count;
	} rsp_t;

	// A long key reads released when its pin is high; "none" counts as released.
	function automatic logic long_key_released(input logic [1:0] lk, input logic [3:0] levels);
		logic rel;
		rel = 1'b1;
		if (lk == LK_CONFIRM) begin
			rel = levels[3];
		end else if (lk == LK_BACK) begin
			rel = levels[0];
		end
		return rel;
	endfunction

endpackage

// ----- hw/rtl/kdq_ifs.sv -----
// Valid/ready channel interfaces for commands and results.
interface kdq_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [1:0] key_index;
	logic [3:0] key_levels;
	logic       menu_mode;
	logic [1:0] long_key;

	modport source (output valid, command, key_index, key_levels, menu_mode, long_key,
		input ready);
	modport sink (input valid, command, key_index, key_levels, menu_mode, long_key,
		output ready);
endinterface

interface kdq_rsp_if;
	logic       valid;
	logic       ready;
	logic       short_valid;
	logic [1:0] short_key;
	logic [1:0] long_action;
	logic       edge_accepted;
	logic       timer_start;
	logic       timer_stop;
	logic [1:0] tracked_key;
	logic       guard_active;
	logic [7:0] overflow_count;
	logic [2:0] queue_count;

	modport source (output valid, short_valid, short_key, long_action, edge_accepted,
		timer_start, timer_stop, tracked_key, guard_active, overflow_count, queue_count,
		input ready);
	modport sink (input valid, short_valid, short_key, long_action, edge_accepted,
		timer_start, timer_stop, tracked_key, guard_active, overflow_count, queue_count,
		output ready);
endinterface

// ----- hw/rtl/key_debounce_event_queue.sv -----
// An accepted command is registered into the s1 stage while the memories are read
// ahead of the read-modify-write; in ST_EXEC its result is registered into out_q
// once the output register is free. A new command is accepted only in ST_IDLE.
// A waiting result does not block acceptance of the next command.
// Reset clears all control state and sets debounce_ms to 50 and guard_ms to
// 200; the edge-time and press memories are not cleared.
module key_debounce_event_queue #(
	parameter int QUEUE_DEPTH = 8,
	parameter int KEY_COUNT   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	kdq_req_if.sink     req,
	kdq_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int KI_W  = $clog2(KEY_COUNT);

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t state_q;

	logic [2:0] cmd_s1;
	logic [1:0] key_s1;
	logic [3:0] levels_s1;
	logic       menu_s1;
	logic [1:0] lk_s1;

	logic [31:0] now_q;
	logic [15:0] debounce_q;
	logic [15:0] guard_ms_q;
	logic [7:0]  drop_q;
	logic [1:0]  pending_q;
	logic [1:0]  tracked_q;
	logic [1:0]  guard_key_q;
	logic        guard_rel_q;
	logic [31:0] guard_time_q;

	logic          out_valid_q;
	kdq_pkg::rsp_t out_q;

	logic accept;
	logic fire;

	logic [31:0] rd_time_s1;
	logic        rd_valid_s1;
	logic [1:0]  ring_data_s1;
	logic [PTR_W:0] used;
	logic [PTR_W:0] used_nx;
	kdq_pkg::ring_ctl_t  ring_ctl;
	kdq_pkg::ring_stat_t ring_stat;

	logic [31:0] now_nx;
	logic [7:0]  drop_nx;
	logic [1:0]  pending_nx;
	logic [1:0]  tracked_nx;
	logic [1:0]  guard_key_nx;
	logic        guard_rel_nx;
	logic [31:0] guard_time_nx;
	logic        edge_wr;
	logic [1:0]  lk;
	logic [31:0] age;
	kdq_pkg::rsp_t res;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign fire      = (state_q == ST_EXEC) && (!out_valid_q || rsp.ready);

	kdq_edge_store #(.KEY_COUNT(KEY_COUNT)) u_edge_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (accept),
		.rd_key      (KI_W'(req.key_index)),
		.wr_en       (edge_wr),
		.wr_key      (KI_W'(key_s1)),
		.wr_time     (now_q),
		.rd_time_s1  (rd_time_s1),
		.rd_valid_s1 (rd_valid_s1)
	);

	kdq_press_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_press_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.ctl        (ring_ctl),
		.rd_data_s1 (ring_data_s1),
		.stat       (ring_stat),
		.used       (used)
	);

	assign lk  = (lk_s1 == kdq_pkg::LK_INVALID) ? kdq_pkg::LK_NONE : lk_s1;
	assign age = now_q - rd_time_s1;

	always_comb begin
		logic [1:0] tracked_tmp;
		logic [1:0] want;
		now_nx        = now_q;
		drop_nx       = drop_q;
		pending_nx    = pending_q;
		tracked_nx    = tracked_q;
		guard_key_nx  = guard_key_q;
		guard_rel_nx  = guard_rel_q;
		guard_time_nx = guard_time_q;
		edge_wr       = 1'b0;
		ring_ctl      = '0;
		ring_ctl.push_key = key_s1;
		res           = '0;
		tracked_tmp   = tracked_q;
		want          = (key_s1 == kdq_pkg::KEY_IDX_BACK) ? kdq_pkg::LK_BACK : kdq_pkg::LK_CONFIRM;

		case (kdq_pkg::cmd_t'(cmd_s1))
			kdq_pkg::CMD_TICK: begin
				now_nx = now_q + 32'd1;
			end
			kdq_pkg::CMD_KEY_EDGE: begin
				// Low level and either the first edge or outside the debounce window.
				if (!levels_s1[key_s1] && !(rd_valid_s1 && age < {16'd0, debounce_q})) begin
					edge_wr = fire;
					res.edge_accepted = 1'b1;
					if (menu_s1) begin
						if (guard_key_q == kdq_pkg::LK_NONE) begin
							if (ring_stat.full) begin
								drop_nx = drop_q + 8'd1;
							end else begin
								ring_ctl.push = fire;
							end
						end
					end else if (key_s1 == kdq_pkg::KEY_IDX_BACK ||
							key_s1 == kdq_pkg::KEY_IDX_CONFIRM) begin
						if (tracked_q != kdq_pkg::LK_NONE &&
								kdq_pkg::long_key_released(tracked_q, levels_s1)) begin
							tracked_tmp = kdq_pkg::LK_NONE;
							res.timer_stop = 1'b1;
						end
						if (tracked_tmp == kdq_pkg::LK_NONE && guard_key_q == kdq_pkg::LK_NONE) begin
							tracked_tmp = want;
							res.timer_start = 1'b1;
						end
						tracked_nx = tracked_tmp;
					end
				end
			end
			kdq_pkg::CMD_TAKE_SHORT: begin
				if (!ring_stat.empty) begin
					res.short_valid = 1'b1;
					res.short_key   = ring_data_s1;
					ring_ctl.pop    = fire;
				end
			end
			kdq_pkg::CMD_TAKE_LONG: begin
				if (pending_q[1]) begin
					res.long_action = kdq_pkg::LK_CONFIRM;
					pending_nx[1]   = 1'b0;
				end else if (pending_q[0]) begin
					res.long_action = kdq_pkg::LK_BACK;
					pending_nx[0]   = 1'b0;
				end
			end
			kdq_pkg::CMD_CLEAR: begin
				ring_ctl.flush = fire;
			end
			kdq_pkg::CMD_ARM_GUARD: begin
				ring_ctl.flush = fire;
				guard_key_nx   = lk;
				guard_rel_nx   = 1'b0;
				guard_time_nx  = now_q;
			end
			kdq_pkg::CMD_UPD_GUARD: begin
				if (guard_key_q != kdq_pkg::LK_NONE) begin
					if (!guard_rel_q) begin
						if (kdq_pkg::long_key_released(guard_key_q, levels_s1)) begin
							guard_rel_nx  = 1'b1;
							guard_time_nx = now_q;
						end
					end else if ((now_q - guard_time_q) >= {16'd0, guard_ms_q}) begin
						guard_key_nx = kdq_pkg::LK_NONE;
						guard_rel_nx = 1'b0;
					end
				end
			end
			kdq_pkg::CMD_LONG_REACH: begin
				if (lk == kdq_pkg::LK_CONFIRM) begin
					pending_nx[1] = 1'b1;
				end else if (lk == kdq_pkg::LK_BACK) begin
					pending_nx[0] = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Queue occupancy after this command takes effect.
		if (ring_ctl.flush) begin
			used_nx = '0;
		end else if (ring_ctl.push) begin
			used_nx = used + 1'b1;
		end else if (ring_ctl.pop) begin
			used_nx = used - 1'b1;
		end else begin
			used_nx = used;
		end

		res.tracked_key    = tracked_nx;
		res.guard_active   = (guard_key_nx != kdq_pkg::LK_NONE);
		res.overflow_count = drop_nx;
		res.queue_count    = 3'(used_nx);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= req.command;
			key_s1    <= req.key_index;
			levels_s1 <= req.key_levels;
			menu_s1   <= req.menu_mode;
			lk_s1     <= req.long_key;
		end
		if (fire) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			now_q        <= '0;
			debounce_q   <= kdq_pkg::DEBOUNCE_RESET;
			guard_ms_q   <= kdq_pkg::GUARD_RESET;
			drop_q       <= '0;
			pending_q    <= '0;
			tracked_q    <= kdq_pkg::LK_NONE;
			guard_key_q  <= kdq_pkg::LK_NONE;
			guard_rel_q  <= 1'b0;
			guard_time_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == kdq_pkg::CFG_DEBOUNCE) begin
					debounce_q <= cfg_wdata;
				end else begin
					guard_ms_q <= cfg_wdata;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q      <= ST_IDLE;
						now_q        <= now_nx;
						drop_q       <= drop_nx;
						pending_q    <= pending_nx;
						tracked_q    <= tracked_nx;
						guard_key_q  <= guard_key_nx;
						guard_rel_q  <= guard_rel_nx;
						guard_time_q <= guard_time_nx;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.short_valid    = out_q.short_valid;
	assign rsp.short_key      = out_q.short_key;
	assign rsp.long_action    = out_q.long_action;
	assign rsp.edge_accepted  = out_q.edge_accepted;
	assign rsp.timer_start    = out_q.timer_start;
	assign rsp.timer_stop     = out_q.timer_stop;
	assign rsp.tracked_key    = out_q.tracked_key;
	assign rsp.guard_active   = out_q.guard_active;
	assign rsp.overflow_count = out_q.overflow_count;
	assign rsp.queue_count    = out_q.queue_count;

endmodule

// ----- hw/rtl/kdq_edge_store.sv -----
// Per-key memory of the last accepted edge time, with valid flags.
module kdq_edge_store #(
	parameter int KEY_COUNT = 4,
	localparam int KI_W = $clog2(KEY_COUNT)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [KI_W-1:0] rd_key,
	input  logic            wr_en,
	input  logic [KI_W-1:0] wr_key,
	input  logic [31:0]     wr_time,
	output logic [31:0]     rd_time_s1,
	output logic            rd_valid_s1
);

	logic [31:0]          time_mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[wr_key] <= wr_time;
		end
		if (rd_en) begin
			rd_time_s1 <= time_mem[rd_key];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_key] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_key];
			end
		end
	end

endmodule

// ----- hw/rtl/kdq_press_ring.sv -----
// Short-press ring buffer: memory plus head and tail pointers.
module kdq_press_ring #(
	parameter int QUEUE_DEPTH = 8,
	localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  kdq_pkg::ring_ctl_t ctl,
	output logic [1:0]         rd_data_s1,
	output kdq_pkg::ring_stat_t stat,
	output logic [PTR_W:0]     used
);

	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W+1)'(QUEUE_DEPTH);

	logic [1:0]       ring_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] head_nx;
	logic [PTR_W-1:0] tail_nx;
	logic [PTR_W:0]   diff;

	assign head_nx = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;

	assign diff = {1'b0, head_q} - {1'b0, tail_q};
	assign used = (head_q >= tail_q) ? diff : diff + DEPTH_W;

	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (head_nx == tail_q);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ring_mem[head_q] <= ctl.push_key;
		end
		if (rd_en) begin
			rd_data_s1 <= ring_mem[tail_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.push) begin
				head_q <= head_nx;
			end
			if (ctl.flush) begin
				tail_q <= head_q;
			end else if (ctl.pop) begin
				tail_q <= tail_nx;
			end
		end
	end

endmodule

// ----- hw/rtl/kdq_checker.sv -----
// Port-level checks of the key debounce and event queue, bound to the top level.
module kdq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       short_valid,
	input logic [1:0] short_key,
	input logic [1:0] long_action,
	input logic       edge_accepted,
	input logic       timer_start,
	input logic       timer_stop,
	input logic [1:0] tracked_key
);

	// Commands are handled one at a time, so an accepted transaction drops ready.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after an accepted transaction");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before it was taken");

	a_short_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !short_valid |-> short_key == 2'd0)
		else $error("short key set without a popped press");

	a_start_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (timer_start || timer_stop) |->
			edge_accepted && !short_valid && long_action == 2'd0 &&
			(!timer_start || tracked_key != 2'd0))
		else $error("long-press timer flags inconsistent with the result");

endmodule

bind key_debounce_event_queue kdq_checker u_kdq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.short_valid   (rsp.short_valid),
	.short_key     (rsp.short_key),
	.long_action   (rsp.long_action),
	.edge_accepted (rsp.edge_accepted),
	.timer_start   (rsp.timer_start),
	.timer_stop    (rsp.timer_stop),
	.tracked_key   (rsp.tracked_key)
);
